/* src/tcow_pkg.sv */
// Shared constants and types for the text character to OLED column writer.
package tcow_pkg;

  localparam int TEXT_COLUMNS = 21;
  localparam int TEXT_LINES   = 8;
  localparam int GLYPH_WIDTH  = 5;
  localparam int CELL_WIDTH   = 6;
  localparam int ROM_DEPTH    = 256 * GLYPH_WIDTH;
  localparam int ROM_AW       = $clog2(ROM_DEPTH);

  localparam logic [7:0] CMD_COL_LOW  = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic [7:0] CMD_PAGE     = 8'hB0;

  // byte slot inside one pixel column group
  localparam logic [1:0] SLOT_COL_LOW  = 2'd0;
  localparam logic [1:0] SLOT_COL_HIGH = 2'd1;
  localparam logic [1:0] SLOT_PAGE     = 2'd2;
  localparam logic [1:0] SLOT_DATA     = 2'd3;

  typedef logic [7:0] byte_t;

  typedef logic [39:0] glyph_t;

  // five glyph bytes, byte 0 in the low bits
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    begin
      case (code)
        8'd0:   g = 40'h0000000000;
        8'd1:   g = 40'h3E5B4F5B3E;
        8'd2:   g = 40'h3E6B4F6B3E;
        8'd3:   g = 40'h1C3E7C3E1C;
        8'd4:   g = 40'h183C7E3C18;
        8'd5:   g = 40'h1C577D571C;
        8'd6:   g = 40'h1C5E7F5E1C;
        8'd7:   g = 40'h00183C1800;
        8'd8:   g = 40'hFFE7C3E7FF;
        8'd9:   g = 40'h0018241800;
        8'd10:  g = 40'hFFE7DBE7FF;
        8'd11:  g = 40'h30483A060E;
        8'd12:  g = 40'h2629792926;
        8'd13:  g = 40'h407F050507;
        8'd14:  g = 40'h407F05253F;
        8'd15:  g = 40'h5A3CE73C5A;
        8'd16:  g = 40'h7F3E1C1C08;
        8'd17:  g = 40'h081C1C3E7F;
        8'd18:  g = 40'h14227F2214;
        8'd19:  g = 40'h5F5F005F5F;
        8'd20:  g = 40'h06097F017F;
        8'd21:  g = 40'h006689956A;
        8'd22:  g = 40'h6060606060;
        8'd23:  g = 40'h94A2FFA294;
        8'd24:  g = 40'h08047E0408;
        8'd25:  g = 40'h10207E2010;
        8'd26:  g = 40'h08082A1C08;
        8'd27:  g = 40'h081C2A0808;
        8'd28:  g = 40'h1E10101010;
        8'd29:  g = 40'h0C1E0C1E0C;
        8'd30:  g = 40'h30383E3830;
        8'd31:  g = 40'h060E3E0E06;
        8'd32:  g = 40'h0000000000;
        8'd33:  g = 40'h00005F0000;
        8'd34:  g = 40'h0007000700;
        8'd35:  g = 40'h147F147F14;
        8'd36:  g = 40'h242A7F2A12;
        8'd37:  g = 40'h2313086462;
        8'd38:  g = 40'h3649562050;
        8'd39:  g = 40'h0008070300;
        8'd40:  g = 40'h001C224100;
        8'd41:  g = 40'h0041221C00;
        8'd42:  g = 40'h2A1C7F1C2A;
        8'd43:  g = 40'h08083E0808;
        8'd44:  g = 40'h0080703000;
        8'd45:  g = 40'h0808080808;
        8'd46:  g = 40'h0000606000;
        8'd47:  g = 40'h2010080402;
        8'd48:  g = 40'h3E5149453E;
        8'd49:  g = 40'h00427F4000;
        8'd50:  g = 40'h7249494946;
        8'd51:  g = 40'h2141494D33;
        8'd52:  g = 40'h1814127F10;
        8'd53:  g = 40'h2745454539;
        8'd54:  g = 40'h3C4A494931;
        8'd55:  g = 40'h4121110907;
        8'd56:  g = 40'h3649494936;
        8'd57:  g = 40'h464949291E;
        8'd58:  g = 40'h0000140000;
        8'd59:  g = 40'h0040340000;
        8'd60:  g = 40'h0008142241;
        8'd61:  g = 40'h1414141414;
        8'd62:  g = 40'h0041221408;
        8'd63:  g = 40'h0201590906;
        8'd64:  g = 40'h3E415D594E;
        8'd65:  g = 40'h7C1211127C;
        8'd66:  g = 40'h7F49494936;
        8'd67:  g = 40'h3E41414122;
        8'd68:  g = 40'h7F4141413E;
        8'd69:  g = 40'h7F49494941;
        8'd70:  g = 40'h7F09090901;
        8'd71:  g = 40'h3E41415173;
        8'd72:  g = 40'h7F0808087F;
        8'd73:  g = 40'h00417F4100;
        8'd74:  g = 40'h2040413F01;
        8'd75:  g = 40'h7F08142241;
        8'd76:  g = 40'h7F40404040;
        8'd77:  g = 40'h7F021C027F;
        8'd78:  g = 40'h7F0408107F;
        8'd79:  g = 40'h3E4141413E;
        8'd80:  g = 40'h7F09090906;
        8'd81:  g = 40'h3E4151215E;
        8'd82:  g = 40'h7F09192946;
        8'd83:  g = 40'h2649494932;
        8'd84:  g = 40'h03017F0103;
        8'd85:  g = 40'h3F4040403F;
        8'd86:  g = 40'h1F2040201F;
        8'd87:  g = 40'h3F4038403F;
        8'd88:  g = 40'h6314081463;
        8'd89:  g = 40'h0304780403;
        8'd90:  g = 40'h6159494D43;
        8'd91:  g = 40'h007F414141;
        8'd92:  g = 40'h0204081020;
        8'd93:  g = 40'h004141417F;
        8'd94:  g = 40'h0402010204;
        8'd95:  g = 40'h4040404040;
        8'd96:  g = 40'h0003070800;
        8'd97:  g = 40'h2054547840;
        8'd98:  g = 40'h7F28444438;
        8'd99:  g = 40'h3844444428;
        8'd100: g = 40'h384444287F;
        8'd101: g = 40'h3854545418;
        8'd102: g = 40'h00087E0902;
        8'd103: g = 40'h18A4A49C78;
        8'd104: g = 40'h7F08040478;
        8'd105: g = 40'h00447D4000;
        8'd106: g = 40'h2040403D00;
        8'd107: g = 40'h7F10284400;
        8'd108: g = 40'h00417F4000;
        8'd109: g = 40'h7C04780478;
        8'd110: g = 40'h7C08040478;
        8'd111: g = 40'h3844444438;
        8'd112: g = 40'hFC18242418;
        8'd113: g = 40'h18242418FC;
        8'd114: g = 40'h7C08040408;
        8'd115: g = 40'h4854545424;
        8'd116: g = 40'h04043F4424;
        8'd117: g = 40'h3C4040207C;
        8'd118: g = 40'h1C2040201C;
        8'd119: g = 40'h3C4030403C;
        8'd120: g = 40'h4428102844;
        8'd121: g = 40'h4C9090907C;
        8'd122: g = 40'h4464544C44;
        8'd123: g = 40'h0008364100;
        8'd124: g = 40'h0000770000;
        8'd125: g = 40'h0041360800;
        8'd126: g = 40'h0201020402;
        8'd127: g = 40'h3C2623263C;
        8'd128: g = 40'h1EA1A16112;
        8'd129: g = 40'h3A4040207A;
        8'd130: g = 40'h3854545559;
        8'd131: g = 40'h2155557941;
        8'd132: g = 40'h2154547841;
        8'd133: g = 40'h2155547840;
        8'd134: g = 40'h2054557940;
        8'd135: g = 40'h0C1E527212;
        8'd136: g = 40'h3955555559;
        8'd137: g = 40'h3954545459;
        8'd138: g = 40'h3955545458;
        8'd139: g = 40'h0000457C41;
        8'd140: g = 40'h0002457D42;
        8'd141: g = 40'h0001457C40;
        8'd142: g = 40'hF0292429F0;
        8'd143: g = 40'hF0282528F0;
        8'd144: g = 40'h7C54554500;
        8'd145: g = 40'h2054547C54;
        8'd146: g = 40'h7C0A097F49;
        8'd147: g = 40'h3249494932;
        8'd148: g = 40'h3248484832;
        8'd149: g = 40'h324A484830;
        8'd150: g = 40'h3A4141217A;
        8'd151: g = 40'h3A42402078;
        8'd152: g = 40'h009DA0A07D;
        8'd153: g = 40'h3944444439;
        8'd154: g = 40'h3D4040403D;
        8'd155: g = 40'h3C24FF2424;
        8'd156: g = 40'h487E494366;
        8'd157: g = 40'h2B2FFC2F2B;
        8'd158: g = 40'hFF0929F620;
        8'd159: g = 40'hC0887E0903;
        8'd160: g = 40'h2054547941;
        8'd161: g = 40'h0000447D41;
        8'd162: g = 40'h3048484A32;
        8'd163: g = 40'h384040227A;
        8'd164: g = 40'h007A0A0A72;
        8'd165: g = 40'h7D0D19317D;
        8'd166: g = 40'h2629292F28;
        8'd167: g = 40'h2629292926;
        8'd168: g = 40'h30484D4020;
        8'd169: g = 40'h3808080808;
        8'd170: g = 40'h0808080838;
        8'd171: g = 40'h2F10C8ACBA;
        8'd172: g = 40'h2F102834FA;
        8'd173: g = 40'h00007B0000;
        8'd174: g = 40'h08142A1422;
        8'd175: g = 40'h22142A1408;
        8'd176: g = 40'hAA005500AA;
        8'd177: g = 40'hAA55AA55AA;
        8'd178: g = 40'h000000FF00;
        8'd179: g = 40'h101010FF00;
        8'd180: g = 40'h141414FF00;
        8'd181: g = 40'h1010FF00FF;
        8'd182: g = 40'h1010F010F0;
        8'd183: g = 40'h141414FC00;
        8'd184: g = 40'h1414F700FF;
        8'd185: g = 40'h0000FF00FF;
        8'd186: g = 40'h1414F404FC;
        8'd187: g = 40'h141417101F;
        8'd188: g = 40'h10101F101F;
        8'd189: g = 40'h1414141F00;
        8'd190: g = 40'h101010F000;
        8'd191: g = 40'h0000001F10;
        8'd192: g = 40'h1010101F10;
        8'd193: g = 40'h101010F010;
        8'd194: g = 40'h000000FF10;
        8'd195: g = 40'h1010101010;
        8'd196: g = 40'h7914121479;
        8'd197: g = 40'h000000FF14;
        8'd198: g = 40'h0000FF00FF;
        8'd199: g = 40'h00001F1017;
        8'd200: g = 40'h0000FC04F4;
        8'd201: g = 40'h1414171017;
        8'd202: g = 40'h1414F404F4;
        8'd203: g = 40'h0000FF00F7;
        8'd204: g = 40'h1414141414;
        8'd205: g = 40'h1414F700F7;
        8'd206: g = 40'h1414141714;
        8'd207: g = 40'h10101F101F;
        8'd208: g = 40'h141414F414;
        8'd209: g = 40'h1010F010F0;
        8'd210: g = 40'h00001F101F;
        8'd211: g = 40'h0000001F14;
        8'd212: g = 40'h000000FC14;
        8'd213: g = 40'h0000F010F0;
        8'd214: g = 40'h3845444538;
        8'd215: g = 40'h141414FF14;
        8'd216: g = 40'h1010101F00;
        8'd217: g = 40'h000000F010;
        8'd218: g = 40'hFFFFFFFFFF;
        8'd219: g = 40'hF0F0F0F0F0;
        8'd220: g = 40'h3C4140413C;
        8'd221: g = 40'h000000FFFF;
        8'd222: g = 40'h0F0F0F0F0F;
        8'd223: g = 40'hFE01494936;
        8'd224: g = 40'h7C2A2A3E14;
        8'd225: g = 40'h7E02020606;
        8'd226: g = 40'h027E027E02;
        8'd227: g = 40'h6355494163;
        8'd228: g = 40'h2055547940;
        8'd229: g = 40'h407E201E20;
        8'd230: g = 40'h06027E0202;
        8'd231: g = 40'h99A5E7A599;
        8'd232: g = 40'h1C2A492A1C;
        8'd233: g = 40'h4C7201724C;
        8'd234: g = 40'h304A4D4D30;
        8'd235: g = 40'h3048784830;
        8'd236: g = 40'hBC625A463D;
        8'd237: g = 40'h3E49494900;
        8'd238: g = 40'h7E0101017E;
        8'd239: g = 40'h2A2A2A2A2A;
        8'd240: g = 40'h44445F4444;
        8'd241: g = 40'h40514A4440;
        8'd242: g = 40'h40444A5140;
        8'd243: g = 40'h0000FF0103;
        8'd244: g = 40'hE080FF0000;
        8'd245: g = 40'h08086B6B08;
        8'd246: g = 40'h3845444538;
        8'd247: g = 40'h060F090F06;
        8'd248: g = 40'h0000181800;
        8'd249: g = 40'h0000101000;
        8'd250: g = 40'h3040FF0101;
        8'd251: g = 40'h001F01011E;
        8'd252: g = 40'h3C4140217C;
        8'd253: g = 40'h003C3C3C3C;
        8'd254: g = 40'h0000000000;
        8'd255: g = 40'h4C9190917C;
        default: g = 40'h0000000000;
      endcase
      // table above is written byte 0 first; reverse into byte 0 low
      glyph_lookup = {g[7:0], g[15:8], g[23:16], g[31:24], g[39:32]};
    end
  endfunction

  // flat ROM view: entry a = byte (a mod 5) of glyph (a / 5)
  function automatic byte_t rom_byte(input logic [ROM_AW-1:0] a);
    logic [7:0]  code;
    logic [2:0]  idx;
    glyph_t      g;
    begin
      // divide by 5 via reciprocal, exact for every ROM address
      code = 8'((27'(a) * 27'd52429) >> 18);
      idx  = 3'(a - 11'(code) * 11'd5);
      g    = glyph_lookup(code);
      rom_byte = g[idx*8 +: 8];
    end
  endfunction

endpackage

/* src/tcow_ram.sv */
// Single-port synchronous ROM with registered read; contents come from the package glyph table.
module tcow_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1280
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= WIDTH'(tcow_pkg::rom_byte(tcow_pkg::ROM_AW'(rd_addr)));
    end
  end

endmodule

/* src/text_char_to_oled_column_writes.sv */
// Top level: turns text characters into OLED column/page commands and glyph data words.
// One character yields 24 output words when the cursor cell is visible, one per cycle from
// the single output port while the receiver holds out_tready high; an invisible cell yields
// no words. The next character is taken on the cycle the current run's last word is staged,
// so a steady stream of visible characters runs with no idle gap between runs. Glyph
// bytes come from a ROM with a registered read, fetched one slot ahead.
module text_char_to_oled_column_writes (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], start_line[15:8], start_column[23:16]
  input  logic        in_tuser,   // load_cursor
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tuser,  // is_data
  output logic        out_tlast
);

  logic [7:0] line_r, line_nxt, col_r, col_nxt;
  logic       busy_r, busy_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] page_r, page_nxt;
  logic [7:0] base_r, base_nxt;
  logic [2:0] ci_r, ci_nxt;
  logic [1:0] slot_r, slot_nxt;

  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       od_r, od_nxt, ol_r, ol_nxt;

  logic       in_acc, stage;
  logic [7:0] cl, cc, xcol;
  logic       vis;
  logic [7:0] rom_q;
  logic       rd_en;
  logic [tcow_pkg::ROM_AW-1:0] rd_addr;

  assign in_acc = in_tvalid && in_tready;
  // a word can be staged when the output register is free or being drained
  assign stage  = busy_r && (!ov_r || out_tready);
  assign in_tready = !busy_r || (stage && ci_r == 3'd5 && slot_r == tcow_pkg::SLOT_DATA);

  assign cl  = in_tuser ? in_tdata[15:8]  : line_r;
  assign cc  = in_tuser ? in_tdata[23:16] : col_r;
  assign vis = cl >= 8'd1 && cl <= 8'(tcow_pkg::TEXT_LINES) &&
               cc >= 8'd1 && cc <= 8'(tcow_pkg::TEXT_COLUMNS);
  assign xcol = base_r + 8'(ci_r);

  // fetch glyph byte during the page slot so it is ready at the data slot
  always_comb begin
    rd_en   = stage && slot_r == tcow_pkg::SLOT_PAGE;
    rd_addr = tcow_pkg::ROM_AW'(code_r) * tcow_pkg::ROM_AW'(tcow_pkg::GLYPH_WIDTH)
              + tcow_pkg::ROM_AW'(ci_r);
  end

  tcow_ram #(.WIDTH(8), .DEPTH(tcow_pkg::ROM_DEPTH)) u_rom (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rom_q)
  );

  always_comb begin
    line_nxt = line_r; col_nxt = col_r; busy_nxt = busy_r;
    code_nxt = code_r; page_nxt = page_r; base_nxt = base_r;
    ci_nxt = ci_r; slot_nxt = slot_r;
    ov_nxt = ov_r && !out_tready; ob_nxt = ob_r; od_nxt = od_r; ol_nxt = ol_r;

    if (stage) begin
      ov_nxt = 1'b1;
      od_nxt = 1'b0;
      ol_nxt = 1'b0;
      case (slot_r)
        tcow_pkg::SLOT_COL_LOW:  ob_nxt = tcow_pkg::CMD_COL_LOW | {4'd0, xcol[3:0]};
        tcow_pkg::SLOT_COL_HIGH: ob_nxt = tcow_pkg::CMD_COL_HIGH | {4'd0, xcol[7:4]};
        tcow_pkg::SLOT_PAGE:     ob_nxt = tcow_pkg::CMD_PAGE | page_r;
        tcow_pkg::SLOT_DATA: begin
          ob_nxt = (ci_r == 3'(tcow_pkg::GLYPH_WIDTH)) ? 8'd0 : rom_q;
          od_nxt = 1'b1;
          ol_nxt = ci_r == 3'(tcow_pkg::CELL_WIDTH - 1);
        end
        default: ob_nxt = 8'd0;
      endcase
      slot_nxt = slot_r + 2'd1;
      if (slot_r == tcow_pkg::SLOT_DATA) begin
        ci_nxt = ci_r + 3'd1;
        if (ci_r == 3'(tcow_pkg::CELL_WIDTH - 1)) busy_nxt = 1'b0;
      end
    end

    if (in_acc) begin
      code_nxt = in_tdata[7:0];
      page_nxt = {4'd0, 4'(cl - 8'd1)};
      base_nxt = 8'((cc - 8'd1) * 8'd6);
      ci_nxt   = 3'd0;
      slot_nxt = tcow_pkg::SLOT_COL_LOW;
      busy_nxt = vis;
      // cursor advance
      col_nxt  = cc + 8'd1;
      line_nxt = cl;
      if (cc + 8'd1 > 8'(tcow_pkg::TEXT_COLUMNS)) begin
        col_nxt  = 8'd1;
        line_nxt = cl + 8'd1;
        if (cl + 8'd1 > 8'(tcow_pkg::TEXT_LINES)) line_nxt = 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 8'd1;
      col_r  <= 8'd1;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      ci_r   <= 3'd0;
      slot_r <= tcow_pkg::SLOT_COL_LOW;
    end else begin
      line_r <= line_nxt;
      col_r  <= col_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      ci_r   <= ci_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    page_r <= page_nxt;
    base_r <= base_nxt;
    ob_r   <= ob_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tuser  = od_r;
  assign out_tlast  = ol_r;

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ol_r |-> od_r) else $error("last word not a data word");
  // a loaded line can be anything; only the column is bounded by the advance
  a_cursor_ok: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= 8'(tcow_pkg::TEXT_COLUMNS))
    else $error("cursor column out of range after advance");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(ob_r)) else $error("output word dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && slot_r != tcow_pkg::SLOT_DATA |-> !in_tready)
    else $error("input taken mid-run");

endmodule

/* dv/tb_text_char_to_oled_column_writes.sv */
// Testbench for the text character to OLED column writer: font lookup, cursor walk, stalls.
module tb_text_char_to_oled_column_writes;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] val;
    logic       is_data;
    logic       last;
  } disp_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  disp_word_t  pending_words[$];
  logic [7:0]  font[256][5];
  logic [7:0]  cur_line = 8'd1;
  logic [7:0]  cur_col = 8'd1;
  int          n_fail = 0;
  int          stall_mode = 0;

  always #6 clk = ~clk;

  text_char_to_oled_column_writes DUT (.*);

  // Character glyphs typed in byte 0 first, as the datasheet table gives them
  initial begin
    logic [39:0] rows[256];
    rows = '{
      40'h0000000000,40'h3E5B4F5B3E,40'h3E6B4F6B3E,40'h1C3E7C3E1C,40'h183C7E3C18,40'h1C577D571C,
      40'h1C5E7F5E1C,40'h00183C1800,40'hFFE7C3E7FF,40'h0018241800,40'hFFE7DBE7FF,40'h30483A060E,
      40'h2629792926,40'h407F050507,40'h407F05253F,40'h5A3CE73C5A,40'h7F3E1C1C08,40'h081C1C3E7F,
      40'h14227F2214,40'h5F5F005F5F,40'h06097F017F,40'h006689956A,40'h6060606060,40'h94A2FFA294,
      40'h08047E0408,40'h10207E2010,40'h08082A1C08,40'h081C2A0808,40'h1E10101010,40'h0C1E0C1E0C,
      40'h30383E3830,40'h060E3E0E06,40'h0000000000,40'h00005F0000,40'h0007000700,40'h147F147F14,
      40'h242A7F2A12,40'h2313086462,40'h3649562050,40'h0008070300,40'h001C224100,40'h0041221C00,
      40'h2A1C7F1C2A,40'h08083E0808,40'h0080703000,40'h0808080808,40'h0000606000,40'h2010080402,
      40'h3E5149453E,40'h00427F4000,40'h7249494946,40'h2141494D33,40'h1814127F10,40'h2745454539,
      40'h3C4A494931,40'h4121110907,40'h3649494936,40'h464949291E,40'h0000140000,40'h0040340000,
      40'h0008142241,40'h1414141414,40'h0041221408,40'h0201590906,40'h3E415D594E,40'h7C1211127C,
      40'h7F49494936,40'h3E41414122,40'h7F4141413E,40'h7F49494941,40'h7F09090901,40'h3E41415173,
      40'h7F0808087F,40'h00417F4100,40'h2040413F01,40'h7F08142241,40'h7F40404040,40'h7F021C027F,
      40'h7F0408107F,40'h3E4141413E,40'h7F09090906,40'h3E4151215E,40'h7F09192946,40'h2649494932,
      40'h03017F0103,40'h3F4040403F,40'h1F2040201F,40'h3F4038403F,40'h6314081463,40'h0304780403,
      40'h6159494D43,40'h007F414141,40'h0204081020,40'h004141417F,40'h0402010204,40'h4040404040,
      40'h0003070800,40'h2054547840,40'h7F28444438,40'h3844444428,40'h384444287F,40'h3854545418,
      40'h00087E0902,40'h18A4A49C78,40'h7F08040478,40'h00447D4000,40'h2040403D00,40'h7F10284400,
      40'h00417F4000,40'h7C04780478,40'h7C08040478,40'h3844444438,40'hFC18242418,40'h18242418FC,
      40'h7C08040408,40'h4854545424,40'h04043F4424,40'h3C4040207C,40'h1C2040201C,40'h3C4030403C,
      40'h4428102844,40'h4C9090907C,40'h4464544C44,40'h0008364100,40'h0000770000,40'h0041360800,
      40'h0201020402,40'h3C2623263C,40'h1EA1A16112,40'h3A4040207A,40'h3854545559,40'h2155557941,
      40'h2154547841,40'h2155547840,40'h2054557940,40'h0C1E527212,40'h3955555559,40'h3954545459,
      40'h3955545458,40'h0000457C41,40'h0002457D42,40'h0001457C40,40'hF0292429F0,40'hF0282528F0,
      40'h7C54554500,40'h2054547C54,40'h7C0A097F49,40'h3249494932,40'h3248484832,40'h324A484830,
      40'h3A4141217A,40'h3A42402078,40'h009DA0A07D,40'h3944444439,40'h3D4040403D,40'h3C24FF2424,
      40'h487E494366,40'h2B2FFC2F2B,40'hFF0929F620,40'hC0887E0903,40'h2054547941,40'h0000447D41,
      40'h3048484A32,40'h384040227A,40'h007A0A0A72,40'h7D0D19317D,40'h2629292F28,40'h2629292926,
      40'h30484D4020,40'h3808080808,40'h0808080838,40'h2F10C8ACBA,40'h2F102834FA,40'h00007B0000,
      40'h08142A1422,40'h22142A1408,40'hAA005500AA,40'hAA55AA55AA,40'h000000FF00,40'h101010FF00,
      40'h141414FF00,40'h1010FF00FF,40'h1010F010F0,40'h141414FC00,40'h1414F700FF,40'h0000FF00FF,
      40'h1414F404FC,40'h141417101F,40'h10101F101F,40'h1414141F00,40'h101010F000,40'h0000001F10,
      40'h1010101F10,40'h101010F010,40'h000000FF10,40'h1010101010,40'h7914121479,40'h000000FF14,
      40'h0000FF00FF,40'h00001F1017,40'h0000FC04F4,40'h1414171017,40'h1414F404F4,40'h0000FF00F7,
      40'h1414141414,40'h1414F700F7,40'h1414141714,40'h10101F101F,40'h141414F414,40'h1010F010F0,
      40'h00001F101F,40'h0000001F14,40'h000000FC14,40'h0000F010F0,40'h3845444538,40'h141414FF14,
      40'h1010101F00,40'h000000F010,40'hFFFFFFFFFF,40'hF0F0F0F0F0,40'h3C4140413C,40'h000000FFFF,
      40'h0F0F0F0F0F,40'hFE01494936,40'h7C2A2A3E14,40'h7E02020606,40'h027E027E02,40'h6355494163,
      40'h2055547940,40'h407E201E20,40'h06027E0202,40'h99A5E7A599,40'h1C2A492A1C,40'h4C7201724C,
      40'h304A4D4D30,40'h3048784830,40'hBC625A463D,40'h3E49494900,40'h7E0101017E,40'h2A2A2A2A2A,
      40'h44445F4444,40'h40514A4440,40'h40444A5140,40'h0000FF0103,40'hE080FF0000,40'h08086B6B08,
      40'h3845444538,40'h060F090F06,40'h0000181800,40'h0000101000,40'h3040FF0101,40'h001F01011E,
      40'h3C4140217C,40'h003C3C3C3C,40'h0000000000,40'h4C9190917C};
    for (int c = 0; c < 256; c++)
      for (int k = 0; k < tcow_pkg::GLYPH_WIDTH; k++)
        font[c][k] = rows[c][39 - 8*k -: 8];
  end

  // expected display words for one character, then step the cursor
  task automatic predict_char(input logic [7:0] code, input logic load,
                              input logic [7:0] ln, input logic [7:0] cl);
    logic [7:0] x;
    disp_word_t w;
    if (load) begin
      cur_line = ln;
      cur_col = cl;
    end
    if (cur_line >= 1 && cur_line <= tcow_pkg::TEXT_LINES &&
        cur_col >= 1 && cur_col <= tcow_pkg::TEXT_COLUMNS)
      for (int i = 0; i < tcow_pkg::CELL_WIDTH; i++) begin
        x = 8'((cur_col - 1) * tcow_pkg::CELL_WIDTH + i);
        w = '{tcow_pkg::CMD_COL_LOW | {4'd0, x[3:0]}, 1'b0, 1'b0};
        pending_words.push_back(w);
        w = '{tcow_pkg::CMD_COL_HIGH | {4'd0, x[7:4]}, 1'b0, 1'b0};
        pending_words.push_back(w);
        w = '{tcow_pkg::CMD_PAGE | {4'd0, 4'(cur_line - 1)}, 1'b0, 1'b0};
        pending_words.push_back(w);
        w = '{(i < tcow_pkg::GLYPH_WIDTH) ? font[code][i] : 8'h00, 1'b1,
              1'(i == tcow_pkg::CELL_WIDTH - 1)};
        pending_words.push_back(w);
      end
    cur_col = cur_col + 8'd1;
    if (cur_col > tcow_pkg::TEXT_COLUMNS) begin
      cur_col = 8'd1;
      cur_line = cur_line + 8'd1;
      if (cur_line > tcow_pkg::TEXT_LINES) cur_line = 8'd1;
    end
  endtask

  int burst_left = 0;

  // valid stays up between words of a burst and drops only for a gap
  task automatic send_char(input logic [7:0] code, input logic load,
                           input logic [7:0] ln, input logic [7:0] cl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {cl, ln, code};
    in_tuser <= load;
    do @(posedge clk); while (!in_tready);
    predict_char(code, load, ln, cl);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // receiver stall pattern, mode changes over the run
  always @(posedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  always @(posedge clk) begin
    disp_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word %h", out_tdata);
        n_fail++;
      end else begin
        e = pending_words.pop_front();
        if (out_tdata !== e.val) begin
          $error("out_byte exp %h got %h", e.val, out_tdata); n_fail++;
        end
        if (out_tuser !== e.is_data) begin
          $error("is_data exp %b got %b", e.is_data, out_tuser); n_fail++;
        end
        if (out_tlast !== e.last) begin
          $error("last exp %b got %b", e.last, out_tlast); n_fail++;
        end
      end
    end
  end

  task automatic test_field_extremes;
    send_char(8'd0, 1'b0, 8'd0, 8'd0);
    send_char(8'd255, 1'b1, 8'd1, 8'd1);
    send_char(8'hAA, 1'b1, 8'd8, 8'd21);   // bottom right, wraps to top left
    send_char(8'h55, 1'b0, 8'hFF, 8'hFF);
    send_char(8'd65, 1'b1, 8'd4, 8'd11);
  endtask

  task automatic test_invisible_cursor;
    send_char(8'd66, 1'b1, 8'd0, 8'd5);
    send_char(8'd67, 1'b1, 8'd3, 8'd0);
    send_char(8'd68, 1'b1, 8'd9, 8'd3);
    send_char(8'd69, 1'b1, 8'd2, 8'd22);
    send_char(8'd70, 1'b1, 8'd255, 8'd255);  // column wraps to 0
    send_char(8'd71, 1'b0, 8'd0, 8'd0);
    send_char(8'd72, 1'b1, 8'd255, 8'd21);   // line wraps to 0
    send_char(8'd73, 1'b0, 8'd0, 8'd0);
    send_char(8'd74, 1'b0, 8'd0, 8'd0);
    send_char(8'd75, 1'b1, 8'd8, 8'd20);
    send_char(8'd76, 1'b0, 8'd0, 8'd0);
    send_char(8'd77, 1'b0, 8'd0, 8'd0);
  endtask

  task automatic test_random_text(input int n);
    logic [7:0] ln, cl;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        ln = 8'($urandom_range(0, 255));
        cl = 8'($urandom_range(0, 255));
      end else begin
        ln = 8'($urandom_range(1, tcow_pkg::TEXT_LINES));
        cl = 8'($urandom_range(1, tcow_pkg::TEXT_COLUMNS));
      end
      send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0), ln, cl);
      if (k % 60 == 59) stall_mode = $urandom_range(0, 2);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    stall_mode = 1;
    test_invisible_cursor();
    drain();
    test_random_text(200);
    drain();
    stall_mode = 2;
    test_random_text(250);
    drain();
    if (n_fail == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #(12ns * 400000);
    $display("TB_ERROR");
    $finish;
  end
endmodule
